// ===== design/frz_pkg.sv =====
// Shared types and constants for the ZYX frame rotation block.
// Used by frz_trig, frz_cell and frame_rotation_zyx; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package frz_pkg;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_NORTH = 2'd0,
      CSR_PITCH = 2'd1,
      CSR_ROLL  = 2'd2
   } csr_index_type;

   // States of the sine and cosine sequencer.
   typedef enum logic [3:0] {
      S_IDLE,
      S_ANGLE,
      S_MULX,
      S_MULX2,
      S_MULTS,
      S_DIVTS,
      S_MULTC,
      S_DIVTC,
      S_ACCUM,
      S_STORE
   } trig_state_type;

   // Per-term tables of the series, indexed by the term number 1 to 11.
   typedef logic [11:0][63:0] recip_tab_type;
   typedef logic [11:0][3:0]  rshift_tab_type;

   // Angles are in hundredths of a degree.
   localparam logic signed [17:0] QUARTER_TURN = 18'sd9000;
   localparam logic signed [17:0] FULL_TURN    = 18'sd36000;
   localparam logic [15:0]        OCTANT       = 16'd4500;

   // Radian conversion and series constants, Q60.
   localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
   localparam logic [63:0] RAD_STEP = (PI_Q60 + 64'd9000) / 64'd18000;
   localparam logic [63:0] ONE_Q60  = 64'd1 << 60;
   localparam logic [3:0]  TERMS    = 4'd11;

   // Step factor of series term k: 2k(2k+1) for sine, (2k-1)2k for cosine.
   function automatic logic [8:0] series_div(input int k, input logic cos_term);
      return cos_term ? 9'((2 * k - 1) * (2 * k)) : 9'((2 * k) * (2 * k + 1));
   endfunction

   // Smallest l with 2^l >= d.
   function automatic logic [3:0] series_log2(input logic [8:0] d);
      logic [3:0] l;
      l = 4'd0;
      while ((10'd1 << l) < {1'b0, d}) l = l + 4'd1;
      return l;
   endfunction

   // Reciprocals ceil(2^(60+l) / d). Every numerator of the series is below
   // 2^60, so (n * m) >> (60 + l) is exactly floor(n / d).
   function automatic recip_tab_type make_recip(input logic cos_term);
      recip_tab_type tab;
      logic [127:0]  num;
      logic [8:0]    d;
      tab = '0;
      for (int k = 1; k <= 11; k++) begin
         d = series_div(k, cos_term);
         num = (128'd1 << (60 + series_log2(d))) + 128'(d) - 128'd1;
         tab[k] = 64'(num / 128'(d));
      end
      return tab;
   endfunction

   function automatic rshift_tab_type make_shift(input logic cos_term);
      rshift_tab_type tab;
      tab = '0;
      for (int k = 1; k <= 11; k++) begin
         tab[k] = series_log2(series_div(k, cos_term));
      end
      return tab;
   endfunction

   localparam recip_tab_type  RECIP_SIN = make_recip(1'b0);
   localparam recip_tab_type  RECIP_COS = make_recip(1'b1);
   localparam rshift_tab_type SHIFT_SIN = make_shift(1'b0);
   localparam rshift_tab_type SHIFT_COS = make_shift(1'b1);

endpackage

`default_nettype wire

// ===== design/frame_rotation_zyx.sv =====
// Top level of the ZYX frame rotation: configuration registers, trig
// sequencer and a chain of three rotation cells. Depends on frz_pkg, frz_trig and frz_cell.
//
//  channel  | direction | handshake           | payload
//  req      | in        | req_valid/req_stall | req_coord_x, req_coord_y, req_coord_z
//  rsp      | out       | rsp_valid/rsp_stall | rsp_rotated_x, rsp_rotated_y, rsp_rotated_z
//  csr      | in        | csr_wr_en           | csr_index, csr_wdata
//
// One beat is accepted per cycle while req_stall is low; its result passes
// through the six cell stages and the output register before it is presented.
// After reset and after every csr write the sequencer recomputes the six
// sines and cosines on the shared multiplier, which also does the series
// divisions by reciprocals; req_stall is high while it works.
// When a result waits on rsp_stall the whole cell chain holds.
`timescale 1ns / 1ps
`default_nettype none

module frame_rotation_zyx
   import frz_pkg::*;
#(
   parameter int TRIG_FRAC_BITS = 30
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic signed [31:0]  req_coord_x,
   input  wire logic signed [31:0]  req_coord_y,
   input  wire logic signed [31:0]  req_coord_z,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [31:0]       rsp_rotated_x,
   output logic signed [31:0]       rsp_rotated_y,
   output logic signed [31:0]       rsp_rotated_z,
   input  wire logic                csr_wr_en,
   input  wire logic [1:0]          csr_index,
   input  wire logic [15:0]         csr_wdata
);

   localparam int TW = TRIG_FRAC_BITS + 2;
   localparam int VW = 36;
   localparam logic signed [VW-1:0] SAT_MAX = VW'(64'sh7FFFFFFF);
   localparam logic signed [VW-1:0] SAT_MIN = -VW'(64'sh80000000);

   // Configuration registers.
   logic signed [15:0] north_ff, pitch_ff, roll_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         north_ff <= '0;
         pitch_ff <= '0;
         roll_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_NORTH: north_ff <= csr_wdata;
            CSR_PITCH: pitch_ff <= csr_wdata;
            CSR_ROLL:  roll_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Sines and cosines.
   logic trig_busy;
   logic signed [TW-1:0] sin_z, cos_z, sin_y, cos_y, sin_x, cos_x;
   frz_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .TW(TW)) u_trig (
      .clock       (clock),
      .reset       (reset),
      .start       (csr_wr_en),
      .north_angle (north_ff),
      .pitch_angle (pitch_ff),
      .roll_angle  (roll_ff),
      .busy        (trig_busy),
      .sin_z       (sin_z),
      .cos_z       (cos_z),
      .sin_y       (sin_y),
      .cos_y       (cos_y),
      .sin_x       (sin_x),
      .cos_x       (cos_x)
   );

   // Flow control: the chain advances unless a result is held.
   logic rsp_valid_ff;
   logic advance, accept;
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance || trig_busy;
   assign accept    = req_valid && !req_stall;

   // Cell chain: Z turn, then Y turn, then X turn.
   logic signed [TW-1:0] nsin_y;
   assign nsin_y = -sin_y;

   logic                 v0, v1, v2;
   logic signed [VW-1:0] x1, y1, z0, x2, z2, y1b, y3, z3, x2b;

   frz_cell #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .TW(TW), .VW(VW)) u_cell_z (
      .clock (clock), .reset (reset), .enable (advance), .in_valid (accept),
      .p_in  ({{(VW-32){req_coord_x[31]}}, req_coord_x}),
      .q_in  ({{(VW-32){req_coord_y[31]}}, req_coord_y}),
      .w_in  ({{(VW-32){req_coord_z[31]}}, req_coord_z}),
      .sin_val (sin_z), .cos_val (cos_z),
      .out_valid (v0), .p_out (x1), .q_out (y1), .w_out (z0)
   );

   frz_cell #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .TW(TW), .VW(VW)) u_cell_y (
      .clock (clock), .reset (reset), .enable (advance), .in_valid (v0),
      .p_in (x1), .q_in (z0), .w_in (y1),
      .sin_val (nsin_y), .cos_val (cos_y),
      .out_valid (v1), .p_out (x2), .q_out (z2), .w_out (y1b)
   );

   frz_cell #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .TW(TW), .VW(VW)) u_cell_x (
      .clock (clock), .reset (reset), .enable (advance), .in_valid (v1),
      .p_in (y1b), .q_in (z2), .w_in (x2),
      .sin_val (sin_x), .cos_val (cos_x),
      .out_valid (v2), .p_out (y3), .q_out (z3), .w_out (x2b)
   );

   // Saturate to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [VW-1:0] v);
      logic signed [VW-1:0] t;
      if (v > SAT_MAX) begin
         t = SAT_MAX;
      end else if (v < SAT_MIN) begin
         t = SAT_MIN;
      end else begin
         t = v;
      end
      return t[31:0];
   endfunction

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v2;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_rotated_x <= sat32(x2b);
         rsp_rotated_y <= sat32(y3);
         rsp_rotated_z <= sat32(z3);
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // No beat enters while the coefficients are being recomputed.
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      trig_busy |-> req_stall)
      else $error("input accepted while trig sequencer busy");

   // A configuration write always restarts the sequencer.
   a_write_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> trig_busy)
      else $error("csr write did not restart trig sequencer");

   // Reset starts a coefficient computation.
   a_reset_computes: assert property (@(posedge clock)
      reset |=> trig_busy)
      else $error("trig sequencer idle after reset");

endmodule

`default_nettype wire

// ===== design/frz_trig.sv =====
// Sine and cosine sequencer for the three configured angles.
// Depends on frz_pkg; one shared 32x32 multiplier, which also divides by the
// series factors through reciprocal multiplication.
`timescale 1ns / 1ps
`default_nettype none

module frz_trig
   import frz_pkg::*;
#(
   parameter int TRIG_FRAC_BITS = 30,
   parameter int TW = TRIG_FRAC_BITS + 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [15:0]   north_angle,
   input  wire logic signed [15:0]   pitch_angle,
   input  wire logic signed [15:0]   roll_angle,
   output logic                      busy,
   output logic signed [TW-1:0]      sin_z,
   output logic signed [TW-1:0]      cos_z,
   output logic signed [TW-1:0]      sin_y,
   output logic signed [TW-1:0]      cos_y,
   output logic signed [TW-1:0]      sin_x,
   output logic signed [TW-1:0]      cos_x
);

   localparam int SH = 60 - TRIG_FRAC_BITS;
   localparam logic [63:0] RND_HALF = 64'd1 << (SH - 1);

   trig_state_type state_ff, state_in;

   logic [1:0]  idx_ff, q_ff;
   logic        swap_ff;
   logic [3:0]  k_ff;
   logic [63:0] ma_ff, mb_ff;
   logic [127:0] acc_ff, acc_in;
   logic [1:0]  mcnt_ff;
   logic [63:0] x2_ff, ss_ff, cc_ff, ts_ff, tc_ff;
   logic signed [TW-1:0] sin_ff [3];
   logic signed [TW-1:0] cos_ff [3];

   // Round a Q60 value half up to the trig fraction width.
   function automatic logic signed [TW-1:0] to_trig(input logic [63:0] v);
      logic [63:0] t;
      t = (v + RND_HALF) >> SH;
      return t[TW-1:0];
   endfunction

   // Angle reduction and octant fold for the angle being worked on.
   logic signed [17:0] sel;
   logic signed [17:0] wrapped;
   logic [15:0] t_ang, r_ang, rr_ang;
   logic [1:0]  q_ang;
   always_comb begin
      case (csr_index_type'(idx_ff))
         CSR_NORTH: sel = {{2{north_angle[15]}}, north_angle} + QUARTER_TURN;
         CSR_PITCH: sel = {{2{pitch_angle[15]}}, pitch_angle};
         default:   sel = {{2{roll_angle[15]}}, roll_angle};
      endcase
      if (sel < 0) begin
         wrapped = sel + FULL_TURN;
      end else if (sel >= FULL_TURN) begin
         wrapped = sel - FULL_TURN;
      end else begin
         wrapped = sel;
      end
      t_ang = wrapped[15:0];
      if (t_ang >= 16'd27000) begin
         q_ang = 2'd3;
         r_ang = t_ang - 16'd27000;
      end else if (t_ang >= 16'd18000) begin
         q_ang = 2'd2;
         r_ang = t_ang - 16'd18000;
      end else if (t_ang >= 16'd9000) begin
         q_ang = 2'd1;
         r_ang = t_ang - 16'd9000;
      end else begin
         q_ang = 2'd0;
         r_ang = t_ang;
      end
      rr_ang = (r_ang > OCTANT) ? (16'd9000 - r_ang) : r_ang;
   end

   // Shared multiplier: four 32x32 partial products, taken in turn by mcnt_ff and summed in acc_ff.
   logic [31:0]  a_part, b_part;
   logic [63:0]  pp;
   logic [6:0]   pp_shift;
   logic         mul_done;
   always_comb begin
      a_part   = mcnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
      b_part   = mcnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
      pp       = {32'd0, a_part} * {32'd0, b_part};
      case (mcnt_ff)
         2'd0:    pp_shift = 7'd0;
         2'd3:    pp_shift = 7'd64;
         default: pp_shift = 7'd32;
      endcase
      acc_in   = ((mcnt_ff == 2'd0) ? 128'd0 : acc_ff) + ({64'd0, pp} << pp_shift);
      mul_done = (mcnt_ff == 2'd3);
   end

   // Division by the series factor: multiply by its reciprocal and shift.
   logic [63:0] rcp_m;
   logic [3:0]  rcp_l;
   logic [63:0] quot;
   always_comb begin
      if (state_ff == S_MULTC || state_ff == S_DIVTC) begin
         rcp_m = RECIP_COS[k_ff];
         rcp_l = SHIFT_COS[k_ff];
      end else begin
         rcp_m = RECIP_SIN[k_ff];
         rcp_l = SHIFT_SIN[k_ff];
      end
      quot = 64'(acc_in >> (7'd60 + {3'd0, rcp_l}));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  state_in = S_IDLE;
         S_ANGLE: state_in = S_MULX;
         S_MULX:  if (mul_done) state_in = S_MULX2;
         S_MULX2: if (mul_done) state_in = S_MULTS;
         S_MULTS: if (mul_done) state_in = S_DIVTS;
         S_DIVTS: if (mul_done) state_in = S_MULTC;
         S_MULTC: if (mul_done) state_in = S_DIVTC;
         S_DIVTC: if (mul_done) state_in = S_ACCUM;
         S_ACCUM: state_in = (k_ff == TERMS) ? S_STORE : S_MULTS;
         S_STORE: state_in = (idx_ff == 2'd2) ? S_IDLE : S_ANGLE;
         default: state_in = S_IDLE;
      endcase
      if (start) begin
         state_in = S_ANGLE;
      end
   end

   // Outputs of the sequencer.
   always_comb begin
      busy = (state_ff != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_ANGLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer datapath.
   logic signed [TW-1:0] s0, c0;
   always_comb begin
      s0 = swap_ff ? to_trig(cc_ff) : to_trig(ss_ff);
      c0 = swap_ff ? to_trig(ss_ff) : to_trig(cc_ff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_MULX || state_ff == S_MULX2 || state_ff == S_MULTS ||
          state_ff == S_DIVTS || state_ff == S_MULTC || state_ff == S_DIVTC) begin
         mcnt_ff <= mcnt_ff + 2'd1;
         acc_ff  <= acc_in;
      end else begin
         mcnt_ff <= 2'd0;
      end
      case (state_ff)
         S_ANGLE: begin
            q_ff    <= q_ang;
            swap_ff <= (r_ang > OCTANT);
            ma_ff   <= {48'd0, rr_ang};
            mb_ff   <= RAD_STEP;
         end
         S_MULX: if (mul_done) begin
            ss_ff <= acc_in[63:0];
            ts_ff <= acc_in[63:0];
            cc_ff <= ONE_Q60;
            tc_ff <= ONE_Q60;
            ma_ff <= acc_in[63:0];
            mb_ff <= acc_in[63:0];
         end
         S_MULX2: if (mul_done) begin
            x2_ff <= acc_in[123:60];
            k_ff  <= 4'd1;
            ma_ff <= ts_ff;
            mb_ff <= acc_in[123:60];
         end
         S_MULTS: if (mul_done) begin
            ma_ff <= acc_in[123:60];
            mb_ff <= rcp_m;
         end
         S_DIVTS: if (mul_done) begin
            ts_ff <= quot;
            ma_ff <= tc_ff;
            mb_ff <= x2_ff;
         end
         S_MULTC: if (mul_done) begin
            ma_ff <= acc_in[123:60];
            mb_ff <= rcp_m;
         end
         S_DIVTC: if (mul_done) begin
            tc_ff <= quot;
         end
         S_ACCUM: begin
            if (k_ff[0]) begin
               ss_ff <= ss_ff - ts_ff;
               cc_ff <= cc_ff - tc_ff;
            end else begin
               ss_ff <= ss_ff + ts_ff;
               cc_ff <= cc_ff + tc_ff;
            end
            k_ff  <= k_ff + 4'd1;
            ma_ff <= ts_ff;
            mb_ff <= x2_ff;
         end
         S_STORE: begin
            case (q_ff)
               2'd0: begin
                  sin_ff[idx_ff] <= s0;
                  cos_ff[idx_ff] <= c0;
               end
               2'd1: begin
                  sin_ff[idx_ff] <= c0;
                  cos_ff[idx_ff] <= -s0;
               end
               2'd2: begin
                  sin_ff[idx_ff] <= -s0;
                  cos_ff[idx_ff] <= -c0;
               end
               default: begin
                  sin_ff[idx_ff] <= -c0;
                  cos_ff[idx_ff] <= s0;
               end
            endcase
         end
         default: begin
         end
      endcase
      if (reset || start) begin
         idx_ff <= 2'd0;
      end else if (state_ff == S_STORE) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   assign sin_z = sin_ff[0];
   assign cos_z = cos_ff[0];
   assign sin_y = sin_ff[1];
   assign cos_y = cos_ff[1];
   assign sin_x = sin_ff[2];
   assign cos_x = cos_ff[2];

endmodule

`default_nettype wire

// ===== design/frz_cell.sv =====
// One rotation cell: turns the pair (p, q) by a fixed sine and cosine
// and passes w along. Two pipeline stages. Depends on frz_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frz_cell
   import frz_pkg::*;
#(
   parameter int TRIG_FRAC_BITS = 30,
   parameter int TW = TRIG_FRAC_BITS + 2,
   parameter int VW = 36
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                enable,
   input  wire logic                in_valid,
   input  wire logic signed [VW-1:0] p_in,
   input  wire logic signed [VW-1:0] q_in,
   input  wire logic signed [VW-1:0] w_in,
   input  wire logic signed [TW-1:0] sin_val,
   input  wire logic signed [TW-1:0] cos_val,
   output logic                     out_valid,
   output logic signed [VW-1:0]     p_out,
   output logic signed [VW-1:0]     q_out,
   output logic signed [VW-1:0]     w_out
);

   localparam int LO = (TW + 1) / 2;
   localparam int HI = TW - LO;
   localparam int PL = VW + LO + 1;
   localparam int PH = VW + HI;
   localparam int SW = VW + TW + 2;
   localparam logic signed [SW-1:0] HALF = SW'(1) <<< (TRIG_FRAC_BITS - 1);

   logic signed [TW-1:0] nsin;
   logic signed [LO:0]   c_lo, s_lo, ns_lo;
   logic signed [HI-1:0] c_hi, s_hi, ns_hi;
   always_comb begin
      nsin  = -sin_val;
      c_lo  = $signed({1'b0, cos_val[LO-1:0]});
      s_lo  = $signed({1'b0, sin_val[LO-1:0]});
      ns_lo = $signed({1'b0, nsin[LO-1:0]});
      c_hi  = cos_val[TW-1:LO];
      s_hi  = sin_val[TW-1:LO];
      ns_hi = nsin[TW-1:LO];
   end

   // Stage one: split partial products.
   logic signed [PL-1:0] pc_lo_ff, qs_lo_ff, pn_lo_ff, qc_lo_ff;
   logic signed [PH-1:0] pc_hi_ff, qs_hi_ff, pn_hi_ff, qc_hi_ff;
   logic signed [VW-1:0] w1_ff;
   logic                 v1_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         pc_lo_ff <= PL'(p_in) * PL'(c_lo);
         pc_hi_ff <= PH'(p_in) * PH'(c_hi);
         qs_lo_ff <= PL'(q_in) * PL'(s_lo);
         qs_hi_ff <= PH'(q_in) * PH'(s_hi);
         pn_lo_ff <= PL'(p_in) * PL'(ns_lo);
         pn_hi_ff <= PH'(p_in) * PH'(ns_hi);
         qc_lo_ff <= PL'(q_in) * PL'(c_lo);
         qc_hi_ff <= PH'(q_in) * PH'(c_hi);
         w1_ff    <= w_in;
      end
   end

   // Stage two: combine, round half up and drop the fraction.
   function automatic logic signed [VW-1:0] combine(
      input logic signed [PH-1:0] ha,
      input logic signed [PH-1:0] hb,
      input logic signed [PL-1:0] la,
      input logic signed [PL-1:0] lb);
      logic signed [SW-1:0] sum;
      logic signed [SW-1:0] shifted;
      sum = ((SW'(ha) + SW'(hb)) <<< LO) + SW'(la) + SW'(lb) + HALF;
      shifted = sum >>> TRIG_FRAC_BITS;
      return shifted[VW-1:0];
   endfunction

   logic signed [VW-1:0] p2_ff, q2_ff, w2_ff;
   logic                 v2_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         p2_ff <= combine(pc_hi_ff, qs_hi_ff, pc_lo_ff, qs_lo_ff);
         q2_ff <= combine(pn_hi_ff, qc_hi_ff, pn_lo_ff, qc_lo_ff);
         w2_ff <= w1_ff;
      end
   end

   // Valid bits move with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign p_out     = p2_ff;
   assign q_out     = q2_ff;
   assign w_out     = w2_ff;

endmodule

`default_nettype wire
